// File: rtl/mts_pkg.sv
// shared types, codes and constants for the timer scheduler
package mts_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam logic [9:0] TICK_MS_RST = 10'd25;
  localparam int unsigned DVD_W = 25;
  localparam int unsigned DVS_W = 10;

  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_KILL = 2'd1;
  localparam logic [1:0] MODE_KILL_ALL = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ZERO_REP = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  owner_id;
    logic [15:0] timer_id;
    logic [23:0] period_ms;
    logic [15:0] repeat_count;
    logic        repeat_forever;
  } mts_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [7:0]  fired_owner;
    logic [15:0] fired_timer;
    logic        last_result;
  } mts_rsp_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] timer;
    logic [23:0] period;
    logic [23:0] remaining;
    logic [15:0] reps;
    logic        endless;
  } mts_slot_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mts_div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_FRD, S_FEV, S_TRD, S_TEV, S_FLUSH, S_DONE
  } mts_state_t;

endpackage

// File: rtl/mts_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module mts_div import mts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output mts_div_stat_t        stat
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, dq_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = rem_sh >= {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: rtl/multi_timer_scheduler_top.sv
// timer slot table: sequencer, slot memory and period divider
// set: the 25-step divider turns the period into ticks, then a read and check of every slot
// kill: a read and check of every slot; kill all: clears all slots at once
// tick: visits every slot and waits on result stalls; slot memory has one read and one write port
// one request at a time; in_ready is low until the last result is registered
// synchronous reset clears all slots and loads tick period 25
module multi_timer_scheduler_top import mts_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mts_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mts_rsp_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [9:0] cfg_data
);

  localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_SLOTS - 1);

  mts_state_t state_r, state_nxt;
  mts_req_t   req_r, req_nxt;
  logic [9:0] tick_ms_r;
  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic       mfound_r, mfound_nxt, ffound_r, ffound_nxt;
  logic [IDX_W-1:0] midx_r, midx_nxt, fidx_r, fidx_nxt;
  logic [1:0] status_r, status_nxt;
  logic       pend_v_r, pend_v_nxt;
  logic [7:0] pend_owner_r, pend_owner_nxt;
  logic [15:0] pend_timer_r, pend_timer_nxt;
  logic       out_valid_r, out_valid_nxt;
  mts_rsp_t   out_r, out_nxt;

  mts_slot_t  mem_r [TIMER_SLOTS];
  mts_slot_t  rd_r;
  logic       we;
  logic [IDX_W-1:0] waddr;
  mts_slot_t  wdata;

  logic       div_start;
  logic [DVD_W-1:0] div_q;
  logic [DVS_W-1:0] tp;
  mts_div_stat_t div_stat;
  logic [23:0] ticks;

  logic       out_free, cur_match, cur_free, m_hit, f_hit;
  logic [IDX_W-1:0] m_idx, f_idx;

  assign tp = (tick_ms_r == '0) ? DVS_W'(1) : tick_ms_r;

  mts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({1'b0, req_r.period_ms} + {15'd0, tp} - DVD_W'(1)),
    .divisor  (tp),
    .quotient (div_q),
    .stat     (div_stat)
  );

  assign ticks = (div_q[23:0] == '0) ? 24'd1 : div_q[23:0];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rd_r <= mem_r[idx_r];
  end

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    cur_match = valid_r[idx_r] && rd_r.owner == req_r.owner_id
                && rd_r.timer == req_r.timer_id;
    cur_free  = !valid_r[idx_r];
    m_hit     = mfound_r || cur_match;
    m_idx     = mfound_r ? midx_r : idx_r;
    f_hit     = ffound_r || cur_free;
    f_idx     = ffound_r ? fidx_r : idx_r;

    state_nxt      = state_r;
    req_nxt        = req_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    mfound_nxt     = mfound_r;
    midx_nxt       = midx_r;
    ffound_nxt     = ffound_r;
    fidx_nxt       = fidx_r;
    status_nxt     = status_r;
    pend_v_nxt     = pend_v_r;
    pend_owner_nxt = pend_owner_r;
    pend_timer_nxt = pend_timer_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    we             = 1'b0;
    waddr          = idx_r;
    wdata          = rd_r;
    div_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          idx_nxt    = '0;
          mfound_nxt = 1'b0;
          ffound_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          case (in_data.mode)
            MODE_SET: begin
              if (!in_data.repeat_forever && in_data.repeat_count == '0) begin
                status_nxt = ST_ZERO_REP;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_DIV;
              end
            end
            MODE_KILL: state_nxt = S_FRD;
            MODE_KILL_ALL: begin
              valid_nxt  = '0;
              status_nxt = ST_OK;
              state_nxt  = S_DONE;
            end
            MODE_TICK: state_nxt = S_TRD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        // divider is started in the cycle after the request is latched
        if (!div_stat.busy && !div_stat.done) begin
          div_start = 1'b1;
        end else if (div_stat.done) begin
          state_nxt = S_FRD;
        end
      end
      S_FRD: state_nxt = S_FEV;
      S_FEV: begin
        if (cur_match && !mfound_r) begin
          mfound_nxt = 1'b1;
          midx_nxt   = idx_r;
        end
        if (cur_free && !ffound_r) begin
          ffound_nxt = 1'b1;
          fidx_nxt   = idx_r;
        end
        if (idx_r == IDX_LAST) begin
          state_nxt = S_DONE;
          if (req_r.mode == MODE_SET) begin
            if (m_hit || f_hit) begin
              we    = 1'b1;
              waddr = m_hit ? m_idx : f_idx;
              wdata.owner     = req_r.owner_id;
              wdata.timer     = req_r.timer_id;
              wdata.period    = ticks;
              wdata.remaining = ticks;
              wdata.reps      = req_r.repeat_forever ? 16'd0 : req_r.repeat_count;
              wdata.endless   = req_r.repeat_forever;
              valid_nxt[waddr] = 1'b1;
              status_nxt = ST_OK;
            end else begin
              status_nxt = ST_FULL;
            end
          end else begin
            if (m_hit) begin
              valid_nxt[m_idx] = 1'b0;
              status_nxt = ST_OK;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_TRD: begin
        if (valid_r[idx_r]) begin
          state_nxt = S_TEV;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TEV: begin
        // a fired slot is held back until the next fire or the flush so the final one can carry last_result
        if (rd_r.remaining > 24'd1 || !pend_v_r || out_free) begin
          if (rd_r.remaining > 24'd1) begin
            we = 1'b1;
            wdata.remaining = rd_r.remaining - 24'd1;
          end else begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{ST_OK, 1'b1, pend_owner_r, pend_timer_r, 1'b0};
            end
            pend_v_nxt     = 1'b1;
            pend_owner_nxt = rd_r.owner;
            pend_timer_nxt = rd_r.timer;
            if (!rd_r.endless && rd_r.reps <= 16'd1) begin
              valid_nxt[idx_r] = 1'b0;
            end else begin
              we = 1'b1;
              if (!rd_r.endless) wdata.reps = rd_r.reps - 16'd1;
              wdata.remaining = (rd_r.period == '0) ? 24'd1 : rd_r.period;
            end
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_TRD;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = pend_v_r ? mts_rsp_t'{ST_OK, 1'b1, pend_owner_r, pend_timer_r, 1'b1}
                             : mts_rsp_t'{ST_OK, 1'b0, 8'd0, 16'd0, 1'b1};
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt   = '{status_r, 1'b0, 8'd0, 16'd0, 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      tick_ms_r   <= TICK_MS_RST;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      if (cfg_valid) tick_ms_r <= cfg_data;
    end
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    mfound_r     <= mfound_nxt;
    midx_r       <= midx_nxt;
    ffound_r     <= ffound_nxt;
    fidx_r       <= fidx_nxt;
    status_r     <= status_nxt;
    pend_owner_r <= pend_owner_nxt;
    pend_timer_r <= pend_timer_nxt;
    out_r        <= out_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/mts_checker.sv
// port-level checks for the timer scheduler, bound to the top level
module mts_checker import mts_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input mts_rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a request");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fired |-> out_data.status == ST_OK)
    else $error("fired result with bad status");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.fired_owner == '0 && out_data.fired_timer == '0)
    else $error("owner or timer set without fire");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_timer_scheduler_top mts_checker u_mts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
